@@ design/vna_pkg.sv @@
package vna_pkg;

    localparam int DEFAULT_DEPTH = 4096;

    localparam int CMD_W   = 2;
    localparam int IDX_W   = 12;
    localparam int POS_W   = 24;
    localparam int NRM_W   = 16;
    localparam int ACC_W   = 64;
    localparam int EDGE_W  = 25;
    localparam int CROSS_W = 52;
    localparam int MUL_W   = 32;
    localparam int PROD_W  = 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE_VERTEX = 2'd0,
        CMD_CLEAR        = 2'd1,
        CMD_ADD_TRIANGLE = 2'd2,
        CMD_READ_NORMAL  = 2'd3
    } command_t;

endpackage

@@ design/vna_ram.sv @@
module vna_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/vertex_normal_accumulator.sv @@
// every command but clear first folds its indices, one compare-subtract step at depth 2048 or
//   more; a read normal takes at most 34 normalising shifts, and none when the accumulator is
//   empty; clear sweeps every entry of the accumulator memory
// throughput: one command at a time; busy stays high until the command is done
// the rate is set by the shared 32x32 multiplier, the bit-serial square root and divider,
//   and the single read port of each memory; results come as a one-cycle strobe
// reset: asynchronous, active low; a clearing pass then zeroes every accumulator
module vertex_normal_accumulator #(
    parameter int VERTEX_DEPTH = vna_pkg::DEFAULT_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [vna_pkg::CMD_W-1:0]           command,
    input  logic [vna_pkg::IDX_W-1:0]           vertex_index,
    input  logic signed [vna_pkg::POS_W-1:0]    pos_x,
    input  logic signed [vna_pkg::POS_W-1:0]    pos_y,
    input  logic signed [vna_pkg::POS_W-1:0]    pos_z,
    input  logic [vna_pkg::IDX_W-1:0]           corner_b,
    input  logic [vna_pkg::IDX_W-1:0]           corner_c,
    output logic                                result_valid,
    output logic signed [vna_pkg::NRM_W-1:0]    normal_x,
    output logic signed [vna_pkg::NRM_W-1:0]    normal_y,
    output logic signed [vna_pkg::NRM_W-1:0]    normal_z,
    output logic [vna_pkg::IDX_W-1:0]           normal_vertex
);

    import vna_pkg::*;

    // number of compare-subtract steps that bring a 12-bit index below the depth
    function automatic int fold_count(int depth);
        int n;
        n = 0;
        while ((longint'(depth) << n) <= longint'((1 << IDX_W) - 1))
        begin
            n++;
        end
        if (n == 0)
        begin
            n = 1;
        end
        return n;
    endfunction

    localparam int AW     = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
    localparam int FOLD_N = fold_count(VERTEX_DEPTH);
    localparam int KW     = (FOLD_N > 1) ? $clog2(FOLD_N) : 1;
    localparam int POSM_W = 3 * POS_W;
    localparam int ACCM_W = 3 * ACC_W;

    typedef enum logic [14:0] {
        S_IDLE   = 15'b000000000000001,
        S_SWEEP  = 15'b000000000000010,
        S_FOLD   = 15'b000000000000100,
        S_POS_WR = 15'b000000000001000,
        S_POS_RD = 15'b000000000010000,
        S_CROSS  = 15'b000000000100000,
        S_ACC    = 15'b000000001000000,
        S_RD_ACC = 15'b000000010000000,
        S_RD_MAG = 15'b000000100000000,
        S_MAX    = 15'b000001000000000,
        S_NORM   = 15'b000010000000000,
        S_SQ     = 15'b000100000000000,
        S_SQRT   = 15'b001000000000000,
        S_DIV    = 15'b010000000000000,
        S_OUT    = 15'b100000000000000
    } state_t;

    // saturating add of a cross product component into a 64-bit accumulator
    function automatic logic [ACC_W-1:0] sat_add(logic signed [ACC_W-1:0] a,
                                                 logic signed [CROSS_W-1:0] b);
        logic signed [ACC_W:0] s;
        s = (ACC_W+1)'(a) + (ACC_W+1)'(b);
        if (s[ACC_W] != s[ACC_W-1])
        begin
            return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        return s[ACC_W-1:0];
    endfunction

    // control
    state_t                    state_reg, state_next;
    logic [5:0]                step_reg, step_next;
    logic [1:0]                comp_reg, comp_next;
    logic [KW-1:0]             fold_k_reg, fold_k_next;
    logic [AW-1:0]             sweep_reg, sweep_next;
    command_t                  cmd_reg, cmd_next;
    logic                      valid_reg, valid_next;

    // command payload
    logic [IDX_W-1:0]          ia_reg, ia_next, ib_reg, ib_next, ic_reg, ic_next;
    logic [POSM_W-1:0]         wpos_reg, wpos_next;

    // triangle path
    logic [POSM_W-1:0]         pa_reg, pa_next, pb_reg, pb_next;
    logic signed [EDGE_W-1:0]  e1_reg [3], e1_next [3], e2_reg [3], e2_next [3];
    logic signed [PROD_W-1:0]  prod_reg, prod_next, hold_reg, hold_next;
    logic signed [CROSS_W-1:0] cross_reg [3], cross_next [3];

    // normalising path
    logic [ACC_W-1:0]          mag_reg [3], mag_next [3];
    logic                      neg_reg [3], neg_next [3];
    logic [ACC_W-1:0]          m_reg, m_next;
    logic [63:0]               sum_reg, sum_next;
    logic [63:0]               rs_reg, rs_next, root_reg, root_next;
    logic [31:0]               len_reg, len_next;
    logic [46:0]               num_reg, num_next;
    logic [31:0]               rem_reg, rem_next;
    logic [16:0]               quo_reg, quo_next;
    logic signed [NRM_W-1:0]   res_reg [3], res_next [3];
    logic [IDX_W-1:0]          nv_reg, nv_next;

    // datapath helpers
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic [31:0]               fold_thresh;
    logic [63:0]               sq_bit, sq_trial;
    logic [46:0]               num_calc;
    logic [32:0]               div_r2;
    logic                      div_qb;
    logic [16:0]               div_q;
    logic [15:0]               div_clamp;
    logic [4:0]                div_bidx;
    logic [ACC_W-1:0]          max01;

    // memories
    logic                      pos_we;
    logic [AW-1:0]             pos_waddr, pos_raddr;
    logic [POSM_W-1:0]         pos_rdata;
    logic                      acc_we;
    logic [AW-1:0]             acc_waddr, acc_raddr;
    logic [ACCM_W-1:0]         acc_wdata, acc_rdata;
    logic [IDX_W-1:0]          corner_sel;

    vna_ram #(
        .WIDTH (POSM_W),
        .DEPTH (VERTEX_DEPTH)
    ) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (wpos_reg),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    // x, y, z accumulators side by side; all zero means cleared
    vna_ram #(
        .WIDTH (ACCM_W),
        .DEPTH (VERTEX_DEPTH)
    ) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    assign busy          = (state_reg != S_IDLE);
    assign result_valid  = valid_reg;
    assign normal_x      = res_reg[0];
    assign normal_y      = res_reg[1];
    assign normal_z      = res_reg[2];
    assign normal_vertex = nv_reg;

    // corner picked by the triangle read and accumulate steps
    always_comb
    begin
        unique case (state_reg == S_ACC ? step_reg[2:1] : step_reg[1:0])
            2'd0:    corner_sel = ia_reg;
            2'd1:    corner_sel = ib_reg;
            default: corner_sel = ic_reg;
        endcase
    end

    // memory ports
    always_comb
    begin
        pos_we    = (state_reg == S_POS_WR);
        pos_waddr = AW'(ia_reg);
        pos_raddr = AW'(corner_sel);

        acc_we    = 1'b0;
        acc_waddr = AW'(corner_sel);
        acc_raddr = (state_reg == S_RD_ACC) ? AW'(ia_reg) : AW'(corner_sel);
        acc_wdata = {sat_add(acc_rdata[3*ACC_W-1:2*ACC_W], cross_reg[0]),
                     sat_add(acc_rdata[2*ACC_W-1:ACC_W], cross_reg[1]),
                     sat_add(acc_rdata[ACC_W-1:0], cross_reg[2])};
        if (state_reg == S_SWEEP)
        begin
            acc_we    = 1'b1;
            acc_waddr = sweep_reg;
            acc_wdata = '0;
        end
        else if (state_reg == S_ACC && step_reg[0])
        begin
            // read issued in the step before, written back before the next corner is read
            acc_we = 1'b1;
        end
    end

    // shared multiplier: cross product terms, then squares of the shifted magnitudes
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_CROSS)
        begin
            unique case (step_reg)
                6'd0:
                begin
                    mul_a = MUL_W'(e1_reg[1]);
                    mul_b = MUL_W'(e2_reg[2]);
                end
                6'd1:
                begin
                    mul_a = MUL_W'(e1_reg[2]);
                    mul_b = MUL_W'(e2_reg[1]);
                end
                6'd2:
                begin
                    mul_a = MUL_W'(e1_reg[2]);
                    mul_b = MUL_W'(e2_reg[0]);
                end
                6'd3:
                begin
                    mul_a = MUL_W'(e1_reg[0]);
                    mul_b = MUL_W'(e2_reg[2]);
                end
                6'd4:
                begin
                    mul_a = MUL_W'(e1_reg[0]);
                    mul_b = MUL_W'(e2_reg[1]);
                end
                6'd5:
                begin
                    mul_a = MUL_W'(e1_reg[1]);
                    mul_b = MUL_W'(e2_reg[0]);
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
        else if (state_reg == S_SQ && step_reg < 6'd3)
        begin
            mul_a = MUL_W'({2'b00, mag_reg[step_reg[1:0]][29:0]});
            mul_b = MUL_W'({2'b00, mag_reg[step_reg[1:0]][29:0]});
        end
    end

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    // arithmetic helpers for the iterative units
    assign fold_thresh = 32'(VERTEX_DEPTH) << fold_k_reg;
    assign sq_bit      = 64'h4000_0000_0000_0000 >> {step_reg[4:0], 1'b0};
    assign sq_trial    = root_reg + sq_bit;
    assign num_calc    = 47'({mag_reg[comp_reg][29:0], 15'd0}) + 47'(len_reg >> 1);
    assign div_bidx    = 5'd17 - step_reg[4:0];
    assign div_r2      = {rem_reg, num_reg[div_bidx]};
    assign div_qb      = (div_r2 >= {1'b0, len_reg});
    assign div_q       = {quo_reg[15:0], div_qb};
    assign div_clamp   = (div_q > 17'd32767) ? 16'd32767 : div_q[15:0];
    assign max01       = (mag_reg[0] > mag_reg[1]) ? mag_reg[0] : mag_reg[1];

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        comp_next   = comp_reg;
        fold_k_next = fold_k_reg;
        sweep_next  = sweep_reg;
        cmd_next    = cmd_reg;
        valid_next  = 1'b0;
        ia_next     = ia_reg;
        ib_next     = ib_reg;
        ic_next     = ic_reg;
        wpos_next   = wpos_reg;
        pa_next     = pa_reg;
        pb_next     = pb_reg;
        e1_next     = e1_reg;
        e2_next     = e2_reg;
        hold_next   = hold_reg;
        cross_next  = cross_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        m_next      = m_reg;
        sum_next    = sum_reg;
        rs_next     = rs_reg;
        root_next   = root_reg;
        len_next    = len_reg;
        num_next    = num_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        res_next    = res_reg;
        nv_next     = nv_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next    = command_t'(command);
                    ia_next     = vertex_index;
                    ib_next     = corner_b;
                    ic_next     = corner_c;
                    wpos_next   = {pos_x, pos_y, pos_z};
                    step_next   = '0;
                    fold_k_next = KW'(FOLD_N - 1);
                    sweep_next  = '0;
                    state_next  = (command == CMD_CLEAR) ? S_SWEEP : S_FOLD;
                end
            end
            S_SWEEP:
            begin
                // one entry a cycle
                if (sweep_reg == AW'(VERTEX_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                sweep_next = sweep_reg + AW'(1);
            end
            S_FOLD:
            begin
                // index modulo depth, one binary compare-subtract a cycle
                if (32'(ia_reg) >= fold_thresh)
                begin
                    ia_next = ia_reg - IDX_W'(fold_thresh);
                end
                if (32'(ib_reg) >= fold_thresh)
                begin
                    ib_next = ib_reg - IDX_W'(fold_thresh);
                end
                if (32'(ic_reg) >= fold_thresh)
                begin
                    ic_next = ic_reg - IDX_W'(fold_thresh);
                end
                fold_k_next = fold_k_reg - KW'(1);
                if (fold_k_reg == '0)
                begin
                    fold_k_next = fold_k_reg;
                    step_next   = '0;
                    unique case (cmd_reg)
                        CMD_WRITE_VERTEX: state_next = S_POS_WR;
                        CMD_ADD_TRIANGLE: state_next = S_POS_RD;
                        CMD_READ_NORMAL:  state_next = S_RD_ACC;
                        default:          state_next = S_IDLE;
                    endcase
                end
            end
            S_POS_WR:
            begin
                state_next = S_IDLE;
            end
            S_POS_RD:
            begin
                step_next = step_reg + 6'd1;
                unique case (step_reg)
                    6'd1:    pa_next = pos_rdata;
                    6'd2:    pb_next = pos_rdata;
                    6'd3:
                    begin
                        // e1 = pc - pa, e2 = pb - pa
                        for (int i = 0; i < 3; i++)
                        begin
                            e1_next[i] = EDGE_W'(signed'(pos_rdata[(2-i)*POS_W +: POS_W]))
                                       - EDGE_W'(signed'(pa_reg[(2-i)*POS_W +: POS_W]));
                            e2_next[i] = EDGE_W'(signed'(pb_reg[(2-i)*POS_W +: POS_W]))
                                       - EDGE_W'(signed'(pa_reg[(2-i)*POS_W +: POS_W]));
                        end
                        step_next  = '0;
                        state_next = S_CROSS;
                    end
                    default:
                    begin
                        pa_next = pa_reg;
                    end
                endcase
            end
            S_CROSS:
            begin
                // even product held, odd product subtracted from it
                step_next = step_reg + 6'd1;
                if (step_reg[0])
                begin
                    hold_next = prod_reg;
                end
                unique case (step_reg)
                    6'd2:    cross_next[0] = CROSS_W'(hold_reg - prod_reg);
                    6'd4:    cross_next[1] = CROSS_W'(hold_reg - prod_reg);
                    6'd6:
                    begin
                        cross_next[2] = CROSS_W'(hold_reg - prod_reg);
                        step_next     = '0;
                        state_next    = S_ACC;
                    end
                    default:
                    begin
                        hold_next = step_reg[0] ? prod_reg : hold_reg;
                    end
                endcase
            end
            S_ACC:
            begin
                step_next = step_reg + 6'd1;
                if (step_reg == 6'd5)
                begin
                    state_next = S_IDLE;
                end
            end
            S_RD_ACC:
            begin
                state_next = S_RD_MAG;
            end
            S_RD_MAG:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    neg_next[i] = acc_rdata[(3-i)*ACC_W-1];
                    mag_next[i] = acc_rdata[(3-i)*ACC_W-1]
                                ? (ACC_W'(0) - acc_rdata[(2-i)*ACC_W +: ACC_W])
                                : acc_rdata[(2-i)*ACC_W +: ACC_W];
                end
                nv_next    = ia_reg;
                state_next = S_MAX;
            end
            S_MAX:
            begin
                m_next = (max01 > mag_reg[2]) ? max01 : mag_reg[2];
                if (max01 == '0 && mag_reg[2] == '0)
                begin
                    // empty accumulator reads as a zero normal
                    for (int i = 0; i < 3; i++)
                    begin
                        res_next[i] = '0;
                    end
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                // bring the largest magnitude into [2^29, 2^30)
                priority if (m_reg >= (ACC_W'(1) << 30))
                begin
                    m_next = m_reg >> 1;
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_next[i] = mag_reg[i] >> 1;
                    end
                end
                else if (m_reg < (ACC_W'(1) << 29))
                begin
                    m_next = m_reg << 1;
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_next[i] = mag_reg[i] << 1;
                    end
                end
                else
                begin
                    sum_next   = '0;
                    step_next  = '0;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                step_next = step_reg + 6'd1;
                if (step_reg != 6'd0)
                begin
                    sum_next = sum_reg + 64'(prod_reg);
                end
                if (step_reg == 6'd3)
                begin
                    rs_next    = sum_reg + 64'(prod_reg);
                    root_next  = '0;
                    step_next  = '0;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                // one result bit a cycle
                step_next = step_reg + 6'd1;
                if (rs_reg >= sq_trial)
                begin
                    rs_next   = rs_reg - sq_trial;
                    root_next = (root_reg >> 1) + sq_bit;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                if (step_reg == 6'd31)
                begin
                    len_next   = (rs_reg >= sq_trial) ? 32'((root_reg >> 1) + sq_bit)
                                                      : 32'(root_reg >> 1);
                    step_next  = '0;
                    comp_next  = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // restoring division, one quotient bit a cycle per component
                step_next = step_reg + 6'd1;
                if (step_reg == 6'd0)
                begin
                    num_next = num_calc;
                    rem_next = 32'(num_calc[46:17]);
                    quo_next = '0;
                end
                else
                begin
                    rem_next = div_qb ? 32'(div_r2 - {1'b0, len_reg}) : div_r2[31:0];
                    quo_next = div_q;
                    if (step_reg == 6'd17)
                    begin
                        res_next[comp_reg] = neg_reg[comp_reg] ? -signed'(div_clamp)
                                                               : signed'(div_clamp);
                        step_next = '0;
                        comp_next = comp_reg + 2'd1;
                        if (comp_reg == 2'd2)
                        begin
                            state_next = S_OUT;
                        end
                    end
                end
            end
            S_OUT:
            begin
                valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_SWEEP;
            step_reg   <= '0;
            comp_reg   <= '0;
            fold_k_reg <= '0;
            sweep_reg  <= '0;
            cmd_reg    <= CMD_WRITE_VERTEX;
            valid_reg  <= 1'b0;
            ia_reg     <= '0;
            ib_reg     <= '0;
            ic_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            comp_reg   <= comp_next;
            fold_k_reg <= fold_k_next;
            sweep_reg  <= sweep_next;
            cmd_reg    <= cmd_next;
            valid_reg  <= valid_next;
            ia_reg     <= ia_next;
            ib_reg     <= ib_next;
            ic_reg     <= ic_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wpos_reg  <= wpos_next;
        pa_reg    <= pa_next;
        pb_reg    <= pb_next;
        e1_reg    <= e1_next;
        e2_reg    <= e2_next;
        prod_reg  <= prod_next;
        hold_reg  <= hold_next;
        cross_reg <= cross_next;
        mag_reg   <= mag_next;
        neg_reg   <= neg_next;
        m_reg     <= m_next;
        sum_reg   <= sum_next;
        rs_reg    <= rs_next;
        root_reg  <= root_next;
        len_reg   <= len_next;
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        res_reg   <= res_next;
        nv_reg    <= nv_next;
    end

`ifndef SYNTHESIS
    a_result_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (!busy && $past(state_reg == S_OUT)))
        else $error("result strobe without a finished read");

    a_result_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

    a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && step_reg != 6'd0) |-> (rem_reg < len_reg))
        else $error("division remainder not below divisor");

    a_index_folded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POS_WR || state_reg == S_POS_RD || state_reg == S_RD_ACC)
        |-> (32'(ia_reg) < 32'(VERTEX_DEPTH) && 32'(ib_reg) < 32'(VERTEX_DEPTH)
             && 32'(ic_reg) < 32'(VERTEX_DEPTH)))
        else $error("vertex index not folded below depth");
`endif

endmodule

@@ verif/vertex_normal_accumulator_test.sv @@
module vertex_normal_accumulator_test;
    import vna_pkg::*;

    localparam int DEPTH = DEFAULT_DEPTH;

    // one command as it goes into the block
    typedef struct {
        command_t                op;
        logic [IDX_W-1:0]        vi;
        logic signed [POS_W-1:0] px, py, pz;
        logic [IDX_W-1:0]        cb, cc;
    } mesh_cmd_t;

    // one normal as it comes out of a read
    typedef struct {
        logic signed [NRM_W-1:0] nx, ny, nz;
        logic [IDX_W-1:0]        vtx;
    } vertex_normal_t;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic [CMD_W-1:0]        command;
    logic [IDX_W-1:0]        vertex_index;
    logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
    logic [IDX_W-1:0]        corner_b, corner_c;
    logic                    result_valid;
    logic signed [NRM_W-1:0] normal_x, normal_y, normal_z;
    logic [IDX_W-1:0]        normal_vertex;

    vertex_normal_accumulator #(.VERTEX_DEPTH(DEPTH)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .vertex_index(vertex_index),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .corner_b(corner_b), .corner_c(corner_c),
        .result_valid(result_valid),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .normal_vertex(normal_vertex)
    );

    mesh_cmd_t      cmd_queue[$];       // commands not yet transferred
    vertex_normal_t normals_due[$];     // normals owed by accepted reads
    int             mismatches = 0;

    // shadow of the block state
    logic signed [POS_W-1:0] shadow_pos[DEPTH][3];
    longint                  shadow_acc[DEPTH][3];
    bit                      shadow_live[DEPTH];

    // vertices the stimulus has written so far, so no triangle reads an unwritten one
    bit                      gen_written[DEPTH];
    int                      written_list[$];

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // signed 64-bit add clamped to the range
    function automatic longint add_clamped(input longint a, input longint b);
        logic signed [64:0] sum;
        sum = 65'(a) + 65'(b);
        if (sum > 65'sh0_7FFF_FFFF_FFFF_FFFF)
            return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (sum < -65'sh0_8000_0000_0000_0000)
            return 64'sh8000_0000_0000_0000;
        return sum[63:0];
    endfunction

    // accumulator scaled to unit length in q1.15
    function automatic vertex_normal_t unit_normal(input longint acc[3],
                                                   input logic [IDX_W-1:0] v);
        vertex_normal_t   r;
        longint unsigned  mag[3];
        longint unsigned  peak, sumsq, rem, root, probe, q;
        logic [NRM_W-1:0] comp[3];
        peak = 0;
        sumsq = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = (acc[i] < 0) ? (64'd0 - 64'(acc[i])) : 64'(acc[i]);
            if (mag[i] > peak) peak = mag[i];
        end
        if (peak == 0)
        begin
            comp = '{default: '0};
        end
        else
        begin
            while (peak >= (64'd1 << 30))
            begin
                peak >>= 1;
                for (int i = 0; i < 3; i++) mag[i] >>= 1;
            end
            while (peak < (64'd1 << 29))
            begin
                peak <<= 1;
                for (int i = 0; i < 3; i++) mag[i] <<= 1;
            end
            for (int i = 0; i < 3; i++) sumsq += mag[i] * mag[i];
            // bitwise integer square root
            rem = sumsq;
            root = 0;
            probe = 64'd1 << 62;
            while (probe > rem) probe >>= 2;
            while (probe != 0)
            begin
                if (rem >= root + probe)
                begin
                    rem -= root + probe;
                    root = (root >> 1) + probe;
                end
                else
                    root >>= 1;
                probe >>= 2;
            end
            for (int i = 0; i < 3; i++)
            begin
                q = (mag[i] * 64'd32768 + root / 2) / root;
                if (q > 64'd32767) q = 64'd32767;
                if (acc[i] < 0) q = 64'd0 - q;
                comp[i] = q[NRM_W-1:0];
            end
        end
        r.nx = comp[0];
        r.ny = comp[1];
        r.nz = comp[2];
        r.vtx = v;
        return r;
    endfunction

    // update the shadow state for one transferred command
    function automatic void predict_command(input mesh_cmd_t c);
        longint edge1[3], edge2[3], cprod[3], acc[3];
        int     corner[3];
        case (c.op)
            CMD_WRITE_VERTEX:
            begin
                shadow_pos[c.vi][0] = c.px;
                shadow_pos[c.vi][1] = c.py;
                shadow_pos[c.vi][2] = c.pz;
            end
            CMD_CLEAR:
                shadow_live = '{default: 1'b0};
            CMD_ADD_TRIANGLE:
            begin
                corner = '{int'(c.vi), int'(c.cb), int'(c.cc)};
                for (int i = 0; i < 3; i++)
                begin
                    edge1[i] = longint'(shadow_pos[c.cc][i]) - longint'(shadow_pos[c.vi][i]);
                    edge2[i] = longint'(shadow_pos[c.cb][i]) - longint'(shadow_pos[c.vi][i]);
                end
                cprod[0] = edge1[1] * edge2[2] - edge1[2] * edge2[1];
                cprod[1] = edge1[2] * edge2[0] - edge1[0] * edge2[2];
                cprod[2] = edge1[0] * edge2[1] - edge1[1] * edge2[0];
                // corners may repeat, so each one is folded in turn
                foreach (corner[k])
                begin
                    if (!shadow_live[corner[k]])
                    begin
                        shadow_acc[corner[k]] = '{default: 0};
                        shadow_live[corner[k]] = 1'b1;
                    end
                    for (int i = 0; i < 3; i++)
                        shadow_acc[corner[k]][i] = add_clamped(shadow_acc[corner[k]][i],
                                                               cprod[i]);
                end
            end
            default:
            begin
                acc = '{default: 0};
                if (shadow_live[c.vi]) acc = shadow_acc[c.vi];
                normals_due.push_back(unit_normal(acc, c.vi));
            end
        endcase
    endfunction

    // queue one command; unused fields carry random noise
    task automatic queue_cmd(input command_t op, input int vi, input int px, input int py,
                             input int pz, input int cb, input int cc);
        mesh_cmd_t c;
        c.op = op;
        c.vi = vi;
        c.px = (op == CMD_WRITE_VERTEX) ? px : $urandom;
        c.py = (op == CMD_WRITE_VERTEX) ? py : $urandom;
        c.pz = (op == CMD_WRITE_VERTEX) ? pz : $urandom;
        c.cb = (op == CMD_ADD_TRIANGLE) ? cb : $urandom;
        c.cc = (op == CMD_ADD_TRIANGLE) ? cc : $urandom;
        if (op == CMD_WRITE_VERTEX && !gen_written[vi])
        begin
            gen_written[vi] = 1'b1;
            written_list.push_back(vi);
        end
        cmd_queue.push_back(c);
    endtask

    task automatic queue_write(input int vi);
        queue_cmd(CMD_WRITE_VERTEX, vi, $urandom, $urandom, $urandom, 0, 0);
    endtask

    function automatic int any_written();
        return written_list[$urandom_range(0, written_list.size() - 1)];
    endfunction

    // stimulus: directed corners first, then mostly well-formed mesh traffic
    initial
    begin
        int pool[$];
        int pick, clears;
        clears = 0;

        // extremes of the position range and of the index range
        queue_cmd(CMD_WRITE_VERTEX, 0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 0, 0);
        queue_cmd(CMD_WRITE_VERTEX, 4095, -24'sh800000, -24'sh800000, 24'sh7FFFFF, 0, 0);
        queue_cmd(CMD_WRITE_VERTEX, 1, 24'sh7FFFFF, -24'sh800000, 0, 0, 0);
        queue_cmd(CMD_WRITE_VERTEX, 2, 0, 0, 0, 0, 0);
        queue_cmd(CMD_WRITE_VERTEX, 3, 1, 0, 0, 0, 0);
        queue_cmd(CMD_WRITE_VERTEX, 4, 0, 1, 0, 0, 0);
        // read before any triangle gives a zero normal
        queue_cmd(CMD_READ_NORMAL, 4095, 0, 0, 0, 0, 0);
        // tiny triangle, then one of the largest extent
        queue_cmd(CMD_ADD_TRIANGLE, 2, 0, 0, 0, 3, 4);
        queue_cmd(CMD_READ_NORMAL, 2, 0, 0, 0, 0, 0);
        queue_cmd(CMD_ADD_TRIANGLE, 0, 0, 0, 0, 4095, 1);
        queue_cmd(CMD_READ_NORMAL, 0, 0, 0, 0, 0, 0);
        queue_cmd(CMD_READ_NORMAL, 4095, 0, 0, 0, 0, 0);
        // degenerate triangle with a repeated corner adds nothing but marks valid
        queue_cmd(CMD_ADD_TRIANGLE, 3, 0, 0, 0, 3, 2);
        queue_cmd(CMD_READ_NORMAL, 3, 0, 0, 0, 0, 0);
        // same vertex on all three corners
        queue_cmd(CMD_ADD_TRIANGLE, 1, 0, 0, 0, 1, 1);
        queue_cmd(CMD_READ_NORMAL, 1, 0, 0, 0, 0, 0);
        // clear drops every accumulator, then a new triangle restarts from zero
        queue_cmd(CMD_CLEAR, 4095, 0, 0, 0, 0, 0);
        queue_cmd(CMD_READ_NORMAL, 0, 0, 0, 0, 0, 0);
        queue_cmd(CMD_ADD_TRIANGLE, 4095, 0, 0, 0, 0, 1);
        queue_cmd(CMD_ADD_TRIANGLE, 4095, 0, 0, 0, 1, 0);
        queue_cmd(CMD_READ_NORMAL, 4095, 0, 0, 0, 0, 0);
        queue_cmd(CMD_READ_NORMAL, 2, 0, 0, 0, 0, 0);
        queue_cmd(CMD_ADD_TRIANGLE, 0, 0, 0, 0, 1, 4095);
        queue_cmd(CMD_READ_NORMAL, 0, 0, 0, 0, 0, 0);

        // a working set of vertices so accumulators build up over many triangles
        repeat (20) pool.push_back($urandom_range(0, DEPTH - 1));
        foreach (pool[i]) queue_write(pool[i]);

        for (int n = 0; n < 910; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
                queue_write(pool[$urandom_range(0, pool.size() - 1)]);
            else if (pick < 16)
                queue_write($urandom_range(0, DEPTH - 1));
            else if (pick < 17 && clears < 8)
            begin
                queue_cmd(CMD_CLEAR, $urandom, 0, 0, 0, 0, 0);
                clears++;
            end
            else if (pick < 62)
            begin
                if ($urandom_range(0, 9) == 0)
                    queue_cmd(CMD_ADD_TRIANGLE, any_written(), 0, 0, 0,
                              any_written(), any_written());
                else
                    queue_cmd(CMD_ADD_TRIANGLE, pool[$urandom_range(0, pool.size() - 1)], 0, 0, 0,
                              pool[$urandom_range(0, pool.size() - 1)],
                              pool[$urandom_range(0, pool.size() - 1)]);
            end
            else if ($urandom_range(0, 4) == 0)
                queue_cmd(CMD_READ_NORMAL, $urandom_range(0, DEPTH - 1), 0, 0, 0, 0, 0);
            else
                queue_cmd(CMD_READ_NORMAL, pool[$urandom_range(0, pool.size() - 1)],
                          0, 0, 0, 0, 0);
        end
    end

    // driver: presents the head of the queue, with random hold-offs between transfers
    int        hold_off = 0;
    mesh_cmd_t in_flight;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start        <= 1'b0;
            command      <= CMD_WRITE_VERTEX;
            vertex_index <= '0;
            pos_x        <= '0;
            pos_y        <= '0;
            pos_z        <= '0;
            corner_b     <= '0;
            corner_c     <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                // transfer taken at this edge
                predict_command(in_flight);
                if (cmd_queue.size() > 80 && $urandom_range(0, 3) == 0)
                    hold_off = $urandom_range(1, 5);
            end
            if (start && busy)
            begin
                // keep presenting the same command
            end
            else if (hold_off > 0)
            begin
                hold_off--;
                start <= 1'b0;
            end
            else if (cmd_queue.size() > 0)
            begin
                in_flight = cmd_queue.pop_front();
                start        <= 1'b1;
                command      <= in_flight.op;
                vertex_index <= in_flight.vi;
                pos_x        <= in_flight.px;
                pos_y        <= in_flight.py;
                pos_z        <= in_flight.pz;
                corner_b     <= in_flight.cb;
                corner_c     <= in_flight.cc;
                // occasional gap before the next command is even offered
                if (cmd_queue.size() > 80 && $urandom_range(0, 7) == 0)
                    hold_off = $urandom_range(1, 5);
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // monitor: each strobe is checked against the oldest owed normal
    always @(posedge clk)
    begin
        vertex_normal_t want;
        if (rst_n && result_valid)
        begin
            if (normals_due.size() == 0)
            begin
                report_mismatch("normal with none owed, vertex", normal_vertex, -1);
            end
            else
            begin
                want = normals_due.pop_front();
                if (normal_x !== want.nx) report_mismatch("normal_x", normal_x, want.nx);
                if (normal_y !== want.ny) report_mismatch("normal_y", normal_y, want.ny);
                if (normal_z !== want.nz) report_mismatch("normal_z", normal_z, want.nz);
                if (normal_vertex !== want.vtx)
                    report_mismatch("normal_vertex", normal_vertex, want.vtx);
            end
        end
    end

    // reset, then wait for the queue to drain and every owed normal to arrive
    initial
    begin
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        wait (cmd_queue.size() == 0 && !start && normals_due.size() == 0);
        // room for a read still in the pipe past the last owed normal
        repeat (200) @(posedge clk);
        if (mismatches == 0 && normals_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #1200000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ files.f @@
design/vna_pkg.sv
design/vna_ram.sv
design/vertex_normal_accumulator.sv
verif/vertex_normal_accumulator_test.sv
